// ----- hw/rtl/rit_pkg.sv -----
// Shared types and constants for the reference-counted inode table.
package rit_pkg;

  localparam int unsigned InodeW = 16;
  localparam int unsigned SlotW = 6;
  localparam int unsigned LinkW = 8;
  localparam int unsigned BlockW = 17;
  localparam int unsigned ZoneW = 16;
  localparam int unsigned ShiftW = 3;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic {
    KIND_GET = 1'b0,
    KIND_PUT = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_FULL     = 3'd2,
    ST_KEPT     = 3'd3,
    ST_RELEASED = 3'd4,
    ST_ERROR    = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ZONE_START = 1'b0,
    CFG_IPB_LOG2   = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_COMMIT
  } state_e;

  typedef struct packed {
    logic              kind;
    logic [InodeW-1:0] inode_number;
    logic [SlotW-1:0]  slot;
    logic [LinkW-1:0]  link_count;
  } rit_in_t;

  typedef struct packed {
    status_e           status;
    logic [SlotW-1:0]  entry_index;
    logic [BlockW-1:0] read_block;
    logic [InodeW-1:0] release_inode;
    logic              free_on_disk;
  } rit_out_t;

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic scan_rd;
    logic commit;
  } rit_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic in_is_put;
    logic out_free;
  } rit_sts_t;

endpackage

// ----- hw/rtl/rit_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rit_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/rit_ctrl.sv -----
// Controller state machine that sequences clearing, scans, puts and commits.
module rit_ctrl
  import rit_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rit_sts_t sts_i,
  output rit_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = sts_i.in_is_put ? S_COMMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> sts_i.out_free)
    else $error("Commit issued while the output register is occupied.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && !sts_i.in_is_put) |=> state_q == S_SCAN)
    else $error("Accepted get did not start a scan.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN_END |-> $past(state_q) == S_SCAN)
    else $error("Scan end reached without a scan.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !in_ready_o && !cmd_o.commit)
    else $error("Item activity during the clearing pass.");
`endif

endmodule

// ----- hw/rtl/rit_dp.sv -----
// Datapath with the entry RAM, scan trackers, configuration and output register.
module rit_dp
  import rit_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned REF_WIDTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rit_in_t             in_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output rit_out_t            out_data_o,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  rit_cmd_t            cmd_i,
  output rit_sts_t            sts_o
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned WordW = InodeW + REF_WIDTH;

  logic [AW-1:0] cnt_q, cnt_d;
  logic chk_vld_q;
  logic [AW-1:0] chk_idx_q;
  rit_in_t req_q;
  logic hit_q, hit_d, free_q, free_d;
  logic [AW-1:0] hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [REF_WIDTH-1:0] hit_refs_q, hit_refs_d;
  logic out_valid_q;
  rit_out_t out_q;
  logic [ZoneW-1:0] zone_q;
  logic [ShiftW-1:0] log2_q;

  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WordW-1:0] ram_wdata, ram_rdata;
  logic [REF_WIDTH-1:0] rd_refs;
  logic [InodeW-1:0] rd_inode;
  logic cnt_last;

  logic wr_en_c;
  logic [AW-1:0] wr_addr_c;
  logic [WordW-1:0] wr_data_c;
  rit_out_t res_c;
  logic slot_oor;

  rit_ram #(
    .WIDTH(WordW),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_refs = ram_rdata[REF_WIDTH-1:0];
  assign rd_inode = ram_rdata[WordW-1:REF_WIDTH];
  assign cnt_last = (cnt_q == AW'(TABLE_ENTRIES - 1));
  assign slot_oor = (32'(req_q.slot) >= TABLE_ENTRIES);

  assign ram_re = cmd_i.scan_rd | (cmd_i.accept & (in_data_i.kind == KIND_PUT));
  assign ram_raddr = cmd_i.scan_rd ? cnt_q : AW'(in_data_i.slot);
  assign ram_we = cmd_i.clear_wr | (cmd_i.commit & wr_en_c);
  assign ram_waddr = cmd_i.clear_wr ? cnt_q : wr_addr_c;
  assign ram_wdata = cmd_i.clear_wr ? '0 : wr_data_c;

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.accept) begin
      cnt_d = '0;
    end else if (cmd_i.clear_wr || cmd_i.scan_rd) begin
      cnt_d = cnt_last ? '0 : cnt_q + AW'(1);
    end
  end

  always_comb begin
    hit_d = hit_q;
    hit_idx_d = hit_idx_q;
    hit_refs_d = hit_refs_q;
    free_d = free_q;
    free_idx_d = free_idx_q;
    if (cmd_i.accept) begin
      hit_d = 1'b0;
      free_d = 1'b0;
    end else if (chk_vld_q) begin
      if (rd_refs != '0) begin
        if (!hit_q && rd_inode == req_q.inode_number) begin
          hit_d = 1'b1;
          hit_idx_d = chk_idx_q;
          hit_refs_d = rd_refs;
        end
      end else if (!free_q) begin
        free_d = 1'b1;
        free_idx_d = chk_idx_q;
      end
    end
  end

  always_comb begin
    wr_en_c = 1'b0;
    wr_addr_c = '0;
    wr_data_c = '0;
    res_c = '0;
    res_c.status = ST_ERROR;
    if (req_q.kind == KIND_GET) begin
      if (hit_q) begin
        res_c.entry_index = SlotW'(hit_idx_q);
        if (&hit_refs_q) begin
          res_c.status = ST_ERROR;
        end else begin
          res_c.status = ST_HIT;
          wr_en_c = 1'b1;
          wr_addr_c = hit_idx_q;
          wr_data_c = {req_q.inode_number, hit_refs_q + REF_WIDTH'(1)};
        end
      end else if (free_q) begin
        res_c.status = ST_MISS;
        res_c.entry_index = SlotW'(free_idx_q);
        res_c.read_block = BlockW'(zone_q) + BlockW'(req_q.inode_number >> log2_q);
        wr_en_c = 1'b1;
        wr_addr_c = free_idx_q;
        wr_data_c = {req_q.inode_number, REF_WIDTH'(1)};
      end else begin
        res_c.status = ST_FULL;
      end
    end else begin
      res_c.entry_index = req_q.slot;
      wr_addr_c = AW'(req_q.slot);
      if (slot_oor || rd_refs == '0) begin
        res_c.status = ST_ERROR;
      end else if (rd_refs == REF_WIDTH'(1)) begin
        res_c.status = ST_RELEASED;
        res_c.release_inode = rd_inode;
        res_c.free_on_disk = (req_q.link_count == '0);
        wr_en_c = 1'b1;
        wr_data_c = {rd_inode, {REF_WIDTH{1'b0}}};
      end else begin
        res_c.status = ST_KEPT;
        wr_en_c = 1'b1;
        wr_data_c = {rd_inode, rd_refs - REF_WIDTH'(1)};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      chk_vld_q <= 1'b0;
      hit_q <= 1'b0;
      free_q <= 1'b0;
      out_valid_q <= 1'b0;
      zone_q <= ZoneW'(2);
      log2_q <= ShiftW'(3);
    end else begin
      cnt_q <= cnt_d;
      chk_vld_q <= cmd_i.scan_rd;
      hit_q <= hit_d;
      free_q <= free_d;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_ZONE_START: zone_q <= cfg_data_i[ZoneW-1:0];
          CFG_IPB_LOG2: log2_q <= cfg_data_i[ShiftW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= cnt_q;
    hit_idx_q <= hit_idx_d;
    hit_refs_q <= hit_refs_d;
    free_idx_q <= free_idx_d;
    if (cmd_i.accept) begin
      req_q <= in_data_i;
    end
    if (cmd_i.commit) begin
      out_q <= res_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  assign sts_o.cnt_last = cnt_last;
  assign sts_o.in_is_put = (in_data_i.kind == KIND_PUT);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

// ----- hw/rtl/refcounted_inode_table_unit.sv -----
// Top level of the reference-counted inode table: controller plus datapath.
// A get reads every entry in turn, one entry read per cycle, and then commits its result to the output register.
// A put reads only the entry at its slot and commits its result with at most one entry write.
// One item is in work at a time; a commit waits while the output register is still occupied.
// After reset a clearing pass zeroes every entry before items are accepted.
// Configuration registers reset to a zone start of 2 and a log2 of 3 and are always writable.
module refcounted_inode_table_unit
  import rit_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned REF_WIDTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rit_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rit_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  rit_cmd_t cmd;
  rit_sts_t sts;

  assign cfg_ready_o = 1'b1;

  rit_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rit_dp #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .REF_WIDTH    (REF_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule
